// File: rtl/b64_pkg.sv
package b64_pkg;

   localparam int QDEPTH = 2;
   localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int CNT_W = $clog2(QDEPTH + 1);

   localparam logic [6:0] PAD_CHAR = 7'h3D;

   localparam logic [1:0] PHASE_START = 2'd0;
   localparam logic [1:0] PHASE_ONE   = 2'd1;
   localparam logic [1:0] PHASE_TWO   = 2'd2;

   // characters one input item produces, oldest in chars[0]
   typedef struct packed {
      logic [3:0][6:0] chars;
      logic [1:0]      cnt_m1;
      logic            last;
   } job_type;

   function automatic logic [6:0] sextet_char(input logic [5:0] v);
      logic [6:0] c;
      c = 7'd0;
      case (v) inside
         [6'd0:6'd25]:  c = 7'd65 + {1'b0, v};
         [6'd26:6'd51]: c = 7'd71 + {1'b0, v};
         [6'd52:6'd61]: c = {1'b0, v} - 7'd4;
         6'd62:         c = 7'h2B;
         default:       c = 7'h2F;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/b64_req_if.sv
interface b64_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/b64_rsp_if.sv
interface b64_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       out_last;

   modport source (output valid, output out_char, output out_last, input ready);
   modport sink (input valid, input out_char, input out_last, output ready);
endinterface

// File: rtl/base64_encoder_unit.sv
// channel    dir  payload                      handshake
// req_chan   in   in_byte[7:0], in_last        valid / ready
// rsp_chan   out  out_char[6:0], out_last      valid / ready
//
// one item in per cycle while the job queue has room; one character out per cycle
// while rsp_chan.ready holds; an item yields 1 to 4 characters, so the sustained
// rate is set by the output register: 3 items inside a message yield 4 characters
// first character passes the queue, then the output register, before it is offered
// synchronous reset clears group state, queue and output valid
// a stalled output backs up the two-entry queue, then drops req_chan.ready
module base64_encoder_unit (
   input  logic      clock,
   input  logic      reset,
   b64_req_if.sink   req_chan,
   b64_rsp_if.source rsp_chan
);

   logic             push, q_full, pop, head_valid;
   b64_pkg::job_type push_job, head_job;

   b64_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push),
      .job      (push_job)
   );

   b64_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   b64_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// File: rtl/b64_front.sv
module b64_front (
   input  logic             clock,
   input  logic             reset,
   b64_req_if.sink          req_chan,
   input  logic             q_full,
   output logic             push,
   output b64_pkg::job_type job
);

   logic [3:0] res_ff, res_in, res_next;
   logic [1:0] phase_ff, phase_in, phase_next;
   logic [7:0] b;

   assign req_chan.ready = !q_full;
   assign push = req_chan.valid && !q_full;
   assign b = req_chan.in_byte;

   always_comb begin
      job.chars = {4{b64_pkg::PAD_CHAR}};
      job.cnt_m1 = 2'd0;
      job.last = req_chan.in_last;
      res_next = 4'd0;
      phase_next = b64_pkg::PHASE_START;
      case (phase_ff)
         b64_pkg::PHASE_ONE: begin
            job.chars[0] = b64_pkg::sextet_char({res_ff[1:0], b[7:4]});
            res_next = b[3:0];
            phase_next = b64_pkg::PHASE_TWO;
         end
         b64_pkg::PHASE_TWO: begin
            job.chars[0] = b64_pkg::sextet_char({res_ff, b[7:6]});
            job.chars[1] = b64_pkg::sextet_char(b[5:0]);
            job.cnt_m1 = 2'd1;
            res_next = 4'd0;
            phase_next = b64_pkg::PHASE_START;
         end
         default: begin
            job.chars[0] = b64_pkg::sextet_char(b[7:2]);
            res_next = {2'b00, b[1:0]};
            phase_next = b64_pkg::PHASE_ONE;
         end
      endcase
      if (req_chan.in_last) begin
         case (phase_next)
            b64_pkg::PHASE_ONE: begin
               job.chars[1] = b64_pkg::sextet_char({res_next[1:0], 4'b0000});
               job.cnt_m1 = 2'd3;
            end
            b64_pkg::PHASE_TWO: begin
               job.chars[1] = b64_pkg::sextet_char({res_next, 2'b00});
               job.cnt_m1 = 2'd2;
            end
            default: begin
            end
         endcase
         res_next = 4'd0;
         phase_next = b64_pkg::PHASE_START;
      end
   end

   assign res_in = push ? res_next : res_ff;
   assign phase_in = push ? phase_next : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= 4'd0;
         phase_ff <= b64_pkg::PHASE_START;
      end else begin
         res_ff <= res_in;
         phase_ff <= phase_in;
      end
   end

endmodule

// File: rtl/b64_queue.sv
module b64_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  b64_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output b64_pkg::job_type head_job
);

   b64_pkg::job_type entry_ff [b64_pkg::QDEPTH];
   logic [b64_pkg::PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [b64_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   localparam logic [b64_pkg::PTR_W-1:0] LAST_PTR = b64_pkg::PTR_W'(b64_pkg::QDEPTH - 1);
   localparam logic [b64_pkg::CNT_W-1:0] FULL_CNT = b64_pkg::CNT_W'(b64_pkg::QDEPTH);

   assign full = (cnt_ff == FULL_CNT);
   assign head_valid = (cnt_ff != '0);
   assign head_job = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && head_valid;

   assign wr_ptr_in = !do_push ? wr_ptr_ff :
                      (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !do_pop ? rd_ptr_ff :
                      (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: rtl/b64_back.sv
module b64_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  b64_pkg::job_type head_job,
   output logic             pop,
   b64_rsp_if.source        rsp_chan
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load, job_end;

   assign load = head_valid && (!valid_ff || rsp_chan.ready);
   assign job_end = (idx_ff == head_job.cnt_m1);
   assign pop = load && job_end;

   assign idx_in = pop ? 2'd0 : (load ? idx_ff + 2'd1 : idx_ff);
   assign valid_in = load ? 1'b1 : (rsp_chan.ready ? 1'b0 : valid_ff);
   assign char_in = load ? head_job.chars[idx_ff] : char_ff;
   assign last_in = load ? (head_job.last && job_end) : last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_chan.valid = valid_ff;
   assign rsp_chan.out_char = char_ff;
   assign rsp_chan.out_last = last_ff;

endmodule
